// ===== src/bitmap_font_text_rasterizer_defines.svh =====
// Assertion macros for the text rasterizer. Each expects clk and rst_n in scope.
`ifndef BITMAP_FONT_TEXT_RASTERIZER_DEFINES_SVH
`define BITMAP_FONT_TEXT_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BFTR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BFTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BFTR_ASSERT_NOW(lbl, ante, cons, msg)
`define BFTR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/bftr_pkg.sv =====
package bftr_pkg;

    localparam int GLYPH_COLUMNS = 5;
    localparam int GLYPH_ROWS    = 7;
    localparam int GLYPH_STEP    = 6;
    localparam int GLYPH_COUNT   = 47;
    localparam int GLYPH_IDX_W   = 6;
    localparam int PAT_W         = GLYPH_COLUMNS * GLYPH_ROWS;
    localparam int ROW_W         = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
    localparam int OFF_W         = 8;
    localparam int SCALE_W       = 5;
    localparam int COLOR_W       = 32;
    localparam int COORD_W       = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;

    localparam logic [SCALE_W-1:0] SCALE_MIN = SCALE_W'(1);
    localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(16);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INK_COLOR   = 1'b1;

    // Character codes with special handling
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_DIGIT_0  = 8'h30;
    localparam logic [7:0] CH_DIGIT_9  = 8'h39;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_PERIOD   = 8'h2E;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_GREATER  = 8'h3E;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // Glyph slots
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_DIGIT_BASE = 6'd26;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_COLON      = 6'd36;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_PERIOD     = 6'd37;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_MINUS      = 6'd38;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_SLASH      = 6'd39;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_GREATER    = 6'd40;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_DOLLAR     = 6'd41;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_AT         = 6'd42;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_LBRACKET   = 6'd43;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_RBRACKET   = 6'd44;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_STAR       = 6'd45;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_BLANK      = 6'd46;

    // One entry per glyph, column 0 in the low byte, bit n of a byte is row n.
    localparam logic [8*GLYPH_COLUMNS-1:0] FONT_ROM [GLYPH_COUNT] = '{
        40'h7E0909097E, 40'h364949497F, 40'h224141413E, 40'h1C2241417F,
        40'h414949497F, 40'h010909097F, 40'h7A4949413E, 40'h7F0808087F,
        40'h00417F4100, 40'h013F414020, 40'h412214087F, 40'h404040407F,
        40'h7F020C027F, 40'h7F1008047F, 40'h3E4141413E, 40'h060909097F,
        40'h5E2151413E, 40'h462919097F, 40'h3149494946, 40'h01017F0101,
        40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
        40'h0304780403, 40'h4345495161, 40'h3E4549513E, 40'h00407F4200,
        40'h4649516142, 40'h314B454121, 40'h107F121418, 40'h3945454527,
        40'h3049494A3C, 40'h0305097101, 40'h3649494936, 40'h1E29494906,
        40'h0000363600, 40'h0000604000, 40'h0808080808, 40'h0204081020,
        40'h0008142241, 40'h122A7F2A24, 40'h3CA19D423C, 40'h0081817E00,
        40'h007E818100, 40'h14083E0814, 40'h0000000000
    };

    typedef enum logic {
        CMD_SET_CURSOR = 1'b0,
        CMD_DRAW       = 1'b1
    } cmd_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_SCAN = 1'b1
    } back_state_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [GLYPH_IDX_W-1:0] glyph;
        logic [COORD_W-1:0]     x;
        logic [COORD_W-1:0]     y;
    } queue_entry_t;

    typedef struct packed {
        logic scanning;
        logic popping;
    } back_status_t;

    function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [7:0] code);
        logic [7:0]             c;
        logic [GLYPH_IDX_W-1:0] idx;
        c = code;
        if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            c = c - CASE_OFFSET;
        end
        if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            idx = GLYPH_IDX_W'(c - CH_UPPER_A);
        end
        else if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            idx = GLYPH_IDX_W'(c - CH_DIGIT_0) + GLYPH_DIGIT_BASE;
        end
        else begin
            case (c)
                CH_COLON:    idx = GLYPH_COLON;
                CH_PERIOD:   idx = GLYPH_PERIOD;
                CH_MINUS:    idx = GLYPH_MINUS;
                CH_UNDER:    idx = GLYPH_MINUS;
                CH_SLASH:    idx = GLYPH_SLASH;
                CH_GREATER:  idx = GLYPH_GREATER;
                CH_DOLLAR:   idx = GLYPH_DOLLAR;
                CH_AT:       idx = GLYPH_AT;
                CH_LBRACKET: idx = GLYPH_LBRACKET;
                CH_RBRACKET: idx = GLYPH_RBRACKET;
                CH_STAR:     idx = GLYPH_STAR;
                default:     idx = GLYPH_BLANK;
            endcase
        end
        return idx;
    endfunction

    // Dots in scan order: bit col*GLYPH_ROWS+row. Bits above the row count drop out.
    function automatic logic [PAT_W-1:0] glyph_pattern(input logic [GLYPH_IDX_W-1:0] idx);
        logic [8*GLYPH_COLUMNS-1:0] cols;
        logic [PAT_W-1:0]           pat;
        cols = FONT_ROM[idx];
        for (int col = 0; col < GLYPH_COLUMNS; col++) begin
            for (int row = 0; row < GLYPH_ROWS; row++) begin
                pat[col*GLYPH_ROWS + row] = cols[col*8 + row];
            end
        end
        return pat;
    endfunction

    function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] s);
        logic [SCALE_W-1:0] r;
        if (s < SCALE_MIN) begin
            r = SCALE_MIN;
        end
        else if (s > SCALE_MAX) begin
            r = SCALE_MAX;
        end
        else begin
            r = s;
        end
        return r;
    endfunction

endpackage

// ===== src/bftr_front.sv =====
// Input side: takes transactions while the queue has room and maps the character code
// to its glyph slot.
module bftr_front
    import bftr_pkg::*;
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [7:0]         char_code,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic               q_full,
    output logic               push,
    output queue_entry_t       push_data
);

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_data.cmd   = cmd_t'(command);
        push_data.glyph = glyph_index(char_code);
        push_data.x     = start_x;
        push_data.y     = start_y;
    end

endmodule

// ===== src/bftr_queue.sv =====
// Small FIFO between classifier and scanner.
module bftr_queue
    import bftr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_data,
    output logic         full,
    input  logic         pop,
    output logic         pop_valid,
    output queue_entry_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_entry_t       mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/bftr_back.sv =====
// Scanner: walks glyph dots one per cycle if not stalled; fills the output register.
module bftr_back
    import bftr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  queue_entry_t       q_data,
    output logic               q_pop,
    input  logic [SCALE_W-1:0] pixel_scale,
    input  logic [COLOR_W-1:0] ink_color,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COORD_W-1:0] rect_x,
    output logic [COORD_W-1:0] rect_y,
    output logic [SCALE_W-1:0] rect_size,
    output logic [COLOR_W-1:0] rect_color,
    output logic               last,
    output back_status_t       status
);

    back_state_t        state_reg, state_next;
    logic [COORD_W-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0] cursor_y_reg, cursor_y_next;
    logic [PAT_W-1:0]   pattern_reg, pattern_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [OFF_W-1:0]   x_off_reg, x_off_next;
    logic [OFF_W-1:0]   y_off_reg, y_off_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;

    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] rect_x_reg, rect_x_next;
    logic [COORD_W-1:0] rect_y_reg, rect_y_next;
    logic [SCALE_W-1:0] rect_size_reg, rect_size_next;
    logic [COLOR_W-1:0] rect_color_reg, rect_color_next;
    logic               last_reg, last_next;

    logic step_ok, rest_zero, advance, emit, finish, take_set, take_draw;

    assign step_ok   = !out_valid_reg || !out_stall;
    assign rest_zero = (pattern_reg[PAT_W-1:1] == '0);
    assign q_pop     = (state_reg == BK_IDLE) && q_valid;
    assign take_set  = q_pop && (q_data.cmd == CMD_SET_CURSOR);
    assign take_draw = q_pop && (q_data.cmd == CMD_DRAW);
    assign advance   = (state_reg == BK_SCAN) && (pattern_reg != '0) && step_ok;
    assign emit      = advance && pattern_reg[0];
    // Done on an empty glyph, or when the dot being stepped over is the last lit one.
    assign finish    = (state_reg == BK_SCAN) &&
                       ((pattern_reg == '0) || (step_ok && rest_zero));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (take_draw)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (finish)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        pattern_next    = pattern_reg;
        row_next        = row_reg;
        x_off_next      = x_off_reg;
        y_off_next      = y_off_reg;
        scale_next      = scale_reg;
        out_valid_next  = out_valid_reg && out_stall;
        rect_x_next     = rect_x_reg;
        rect_y_next     = rect_y_reg;
        rect_size_next  = rect_size_reg;
        rect_color_next = rect_color_reg;
        last_next       = last_reg;

        if (take_set)
        begin
            cursor_x_next = q_data.x;
            cursor_y_next = q_data.y;
        end
        if (take_draw)
        begin
            pattern_next = glyph_pattern(q_data.glyph);
            row_next     = '0;
            x_off_next   = '0;
            y_off_next   = '0;
            scale_next   = clamp_scale(pixel_scale);
        end
        if (advance)
        begin
            pattern_next = pattern_reg >> 1;
            if (row_reg == ROW_W'(GLYPH_ROWS - 1))
            begin
                row_next   = '0;
                y_off_next = '0;
                x_off_next = x_off_reg + OFF_W'(scale_reg);
            end
            else
            begin
                row_next   = row_reg + 1'b1;
                y_off_next = y_off_reg + OFF_W'(scale_reg);
            end
        end
        if (emit)
        begin
            out_valid_next  = 1'b1;
            rect_x_next     = cursor_x_reg + COORD_W'(x_off_reg);
            rect_y_next     = cursor_y_reg + COORD_W'(y_off_reg);
            rect_size_next  = scale_reg;
            rect_color_next = ink_color;
            last_next       = rest_zero;
        end
        if (finish)
        begin
            cursor_x_next = cursor_x_reg + COORD_W'(COORD_W'(GLYPH_STEP) * COORD_W'(scale_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pattern_reg    <= pattern_next;
        row_reg        <= row_next;
        x_off_reg      <= x_off_next;
        y_off_reg      <= y_off_next;
        scale_reg      <= scale_next;
        rect_x_reg     <= rect_x_next;
        rect_y_reg     <= rect_y_next;
        rect_size_reg  <= rect_size_next;
        rect_color_reg <= rect_color_next;
        last_reg       <= last_next;
    end

    assign out_valid       = out_valid_reg;
    assign rect_x          = rect_x_reg;
    assign rect_y          = rect_y_reg;
    assign rect_size       = rect_size_reg;
    assign rect_color      = rect_color_reg;
    assign last            = last_reg;
    assign status.scanning = (state_reg == BK_SCAN);
    assign status.popping  = q_pop;

endmodule

// ===== src/bitmap_font_text_rasterizer.sv =====
// Text rasterizer with a built-in 5x7 font. Send a set-cursor transaction (command 0)
// to place the pen at start_x/start_y, then one draw transaction (command 1) per
// character. Each lit dot of the glyph comes out as one filled square of side
// pixel_scale (0 acts as 1, above 16 acts as 16), dots in column order and top to
// bottom inside a column; last marks the final square of a character. Lowercase draws
// as uppercase, '_' as '-', and codes without a glyph draw nothing but still move the
// pen right by 6*scale. Coordinates wrap at 16 bits. A set-cursor only moves the pen;
// a character is loaded, then scanned one dot position at a time up to its last lit
// dot (a blank glyph ends right after the load), giving at most 35 squares; an output
// stall holds the scan. A short input queue lets transactions be taken while the
// scanner works.
// Write pixel_scale and ink_color only while nothing is in flight.
`include "bitmap_font_text_rasterizer_defines.svh"

module bitmap_font_text_rasterizer
    import bftr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // Character transactions
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic [7:0]            char_code,
    input  logic [COORD_W-1:0]    start_x,
    input  logic [COORD_W-1:0]    start_y,

    // Square transactions
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_W-1:0]    rect_x,
    output logic [COORD_W-1:0]    rect_y,
    output logic [SCALE_W-1:0]    rect_size,
    output logic [COLOR_W-1:0]    rect_color,
    output logic                  last
);

    logic [SCALE_W-1:0] pixel_scale_reg, pixel_scale_next;
    logic [COLOR_W-1:0] ink_color_reg, ink_color_next;

    logic               q_push, q_full, q_pop, q_valid;
    queue_entry_t       q_push_data, q_pop_data;
    back_status_t       back_status;

    // Config registers. Raw scale is stored; clamping happens when a character starts.
    always_comb
    begin
        pixel_scale_next = pixel_scale_reg;
        ink_color_next   = ink_color_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PIXEL_SCALE: pixel_scale_next = cfg_data[SCALE_W-1:0];
                REG_INK_COLOR:   ink_color_next   = cfg_data[COLOR_W-1:0];
                default:         pixel_scale_next = pixel_scale_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_scale_reg <= SCALE_MIN;
            ink_color_reg   <= '1;
        end
        else
        begin
            pixel_scale_reg <= pixel_scale_next;
            ink_color_reg   <= ink_color_next;
        end
    end

    // Front: accept and classify
    bftr_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .char_code (char_code),
        .start_x   (start_x),
        .start_y   (start_y),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    bftr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_pop_data)
    );

    // Back: cursor state, dot scan, output register
    bftr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .pixel_scale (pixel_scale_reg),
        .ink_color   (ink_color_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_size   (rect_size),
        .rect_color  (rect_color),
        .last        (last),
        .status      (back_status)
    );

    // Checks
    `BFTR_ASSERT_NOW(a_no_push_when_full, q_push, !q_full, "push into full queue")
    `BFTR_ASSERT_NOW(a_pop_only_idle, back_status.popping, !back_status.scanning && q_valid, "queue popped mid-character")
    `BFTR_ASSERT_NOW(a_size_in_range, out_valid, (rect_size != '0) && (rect_size <= SCALE_MAX), "square size out of range")
    `BFTR_ASSERT_NEXT(a_draw_starts_scan, back_status.popping && (q_pop_data.cmd == CMD_DRAW), back_status.scanning, "draw did not start a scan")

endmodule
